FILE: src/aec_pkg.sv
// shared types, level and beep codes, and register constants for the alarm escalation controller
package aec_pkg;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int DWELL_W = 20;
    localparam int TIME_W  = 32;

    // alarm levels, 1 is the highest alarm
    localparam logic [2:0] LVL_DISARMED = 3'd0;
    localparam logic [2:0] LVL_SIREN    = 3'd1;
    localparam logic [2:0] LVL_SHOUT    = 3'd2;
    localparam logic [2:0] LVL_SPEAK    = 3'd3;
    localparam logic [2:0] LVL_WARN     = 3'd4;
    localparam logic [2:0] LVL_GUARD    = 3'd5;

    localparam logic [2:0] BEEP_NONE       = 3'd0;
    localparam logic [2:0] BEEP_SHORT      = 3'd1;
    localparam logic [2:0] BEEP_DOUBLE     = 3'd2;
    localparam logic [2:0] BEEP_LONG_TWICE = 3'd4;

    // register indexes (word address)
    localparam logic [1:0] REG_WARN  = 2'd0;
    localparam logic [1:0] REG_SPEAK = 2'd1;
    localparam logic [1:0] REG_SHOUT = 2'd2;

    localparam logic [DWELL_W-1:0] WARN_DWELL_RST  = 20'd8000;
    localparam logic [DWELL_W-1:0] SPEAK_DWELL_RST = 20'd8000;
    localparam logic [DWELL_W-1:0] SHOUT_DWELL_RST = 20'd10000;

    typedef struct packed {
        logic [DWELL_W-1:0] warn;
        logic [DWELL_W-1:0] speak;
        logic [DWELL_W-1:0] shout;
    } dwell_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              armed;
        logic              gate_open;
        logic              lockdown;
        logic              reset_press;
    } poll_t;

    typedef struct packed {
        logic [2:0] next_level;
        logic [2:0] beep;
        logic       hold;
        logic       changed;
    } step_res_t;

endpackage

FILE: src/aec_cfg.sv
// apb register file holding the three dwell thresholds
module aec_cfg
    import aec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output dwell_cfg_t        dwell_cfg
);

    logic [DWELL_W-1:0] warn_reg;
    logic [DWELL_W-1:0] speak_reg;
    logic [DWELL_W-1:0] shout_reg;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg  <= WARN_DWELL_RST;
            speak_reg <= SPEAK_DWELL_RST;
            shout_reg <= SHOUT_DWELL_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WARN:  warn_reg  <= pwdata[DWELL_W-1:0];
                REG_SPEAK: speak_reg <= pwdata[DWELL_W-1:0];
                REG_SHOUT: shout_reg <= pwdata[DWELL_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WARN:  prdata = {{(DATA_W-DWELL_W){1'b0}}, warn_reg};
            REG_SPEAK: prdata = {{(DATA_W-DWELL_W){1'b0}}, speak_reg};
            REG_SHOUT: prdata = {{(DATA_W-DWELL_W){1'b0}}, shout_reg};
            default:   prdata = '0;
        endcase
    end

    assign dwell_cfg.warn  = warn_reg;
    assign dwell_cfg.speak = speak_reg;
    assign dwell_cfg.shout = shout_reg;

endmodule

FILE: src/aec_step.sv
// combinational level transition for one poll
module aec_step
    import aec_pkg::*;
(
    input  logic [2:0]        level,
    input  logic [TIME_W-1:0] entry_time,
    input  logic              hold,
    input  poll_t             poll,
    input  dwell_cfg_t        dwell_cfg,
    output step_res_t         res
);

    logic [DWELL_W-1:0] limit;
    logic [TIME_W-1:0]  dwell;
    logic               reached;

    always_comb
    begin
        case (level)
            LVL_WARN:  limit = dwell_cfg.warn;
            LVL_SPEAK: limit = dwell_cfg.speak;
            default:   limit = dwell_cfg.shout;
        endcase
    end

    // wrap-safe elapsed time at the current level
    assign dwell   = poll.now_ms - entry_time;
    assign reached = dwell >= {{(TIME_W-DWELL_W){1'b0}}, limit};

    always_comb
    begin
        res.next_level = level;
        res.beep       = BEEP_NONE;
        res.hold       = hold;
        if (poll.reset_press)
        begin
            res.hold       = 1'b1;
            res.next_level = LVL_GUARD;
            res.beep       = BEEP_SHORT;
        end
        else
        begin
            case (level)
                LVL_DISARMED:
                begin
                    if (poll.armed)
                    begin
                        res.next_level = LVL_GUARD;
                        res.beep       = BEEP_DOUBLE;
                    end
                end
                LVL_GUARD:
                begin
                    if (!poll.armed)
                    begin
                        res.next_level = LVL_DISARMED;
                        res.beep       = BEEP_SHORT;
                    end
                    else if (!poll.gate_open)
                    begin
                        res.hold = 1'b0;
                    end
                    else if (!hold)
                    begin
                        if (poll.lockdown)
                        begin
                            res.next_level = LVL_SHOUT;
                            res.beep       = BEEP_LONG_TWICE;
                        end
                        else
                        begin
                            res.next_level = LVL_WARN;
                            res.beep       = BEEP_DOUBLE;
                        end
                    end
                end
                LVL_WARN, LVL_SPEAK:
                begin
                    if (!poll.armed)
                    begin
                        res.next_level = LVL_DISARMED;
                        res.beep       = BEEP_SHORT;
                    end
                    else if (!poll.gate_open)
                    begin
                        res.next_level = LVL_GUARD;
                        res.beep       = BEEP_SHORT;
                    end
                    else if (reached)
                    begin
                        res.next_level = level - 3'd1;
                        res.beep       = BEEP_DOUBLE;
                    end
                end
                LVL_SHOUT:
                begin
                    if (!poll.armed)
                    begin
                        res.next_level = LVL_DISARMED;
                        res.beep       = BEEP_SHORT;
                    end
                    else if (reached)
                    begin
                        res.next_level = LVL_SIREN;
                        res.beep       = BEEP_LONG_TWICE;
                    end
                end
                LVL_SIREN:
                begin
                    if (!poll.armed)
                    begin
                        res.next_level = LVL_DISARMED;
                        res.beep       = BEEP_SHORT;
                    end
                end
                default: ;
            endcase
        end
        res.changed = (res.next_level != level);
    end

endmodule

FILE: src/alarm_escalation_controller_core.sv
// top level of the alarm escalation controller: poll register, level state and result register
//
//  channel  handshake               payload
//  poll in  in_valid / in_ready     now_ms, armed, gate_open, lockdown, reset_press
//  result   out_valid / out_ready   acting_level, new_level, beep_code, level_changed
//  config   apb psel/penable/pready paddr, pwdata, prdata (dwell thresholds)
//
// one poll per cycle sustained while the result side is not stalled; a poll passes from
// the poll register through the level logic into the result register
// the level state is updated in the same cycle, so the next poll sees it at once
// a stalled result holds; the poll register still takes one more transaction behind it
// reset: level disarmed, entry time 0, hold clear, thresholds 8000/8000/10000 ms
module alarm_escalation_controller_core
    import aec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TIME_W-1:0] now_ms,
    input  logic              armed,
    input  logic              gate_open,
    input  logic              lockdown,
    input  logic              reset_press,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        acting_level,
    output logic [2:0]        new_level,
    output logic [2:0]        beep_code,
    output logic              level_changed
);

    dwell_cfg_t        dwell_cfg;
    step_res_t         res;
    poll_t             poll_reg;
    logic              poll_valid_reg;
    logic              poll_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [2:0]        level_reg;
    logic [2:0]        level_next;
    logic [TIME_W-1:0] entry_reg;
    logic [TIME_W-1:0] entry_next;
    logic              hold_reg;
    logic              hold_next;
    logic [2:0]        acting_reg;
    logic [2:0]        new_level_reg;
    logic [2:0]        beep_reg;
    logic              changed_reg;
    logic              out_free;
    logic              poll_go;
    logic              in_take;

    aec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .dwell_cfg (dwell_cfg)
    );

    aec_step u_step (
        .level      (level_reg),
        .entry_time (entry_reg),
        .hold       (hold_reg),
        .poll       (poll_reg),
        .dwell_cfg  (dwell_cfg),
        .res        (res)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign poll_go  = poll_valid_reg && out_free;
    assign in_ready = !poll_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        poll_valid_next = poll_valid_reg;
        if (in_take)
            poll_valid_next = 1'b1;
        else if (poll_go)
            poll_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (poll_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;

        level_next = level_reg;
        entry_next = entry_reg;
        hold_next  = hold_reg;
        if (poll_go)
        begin
            level_next = res.next_level;
            hold_next  = res.hold;
            if (res.changed)
                entry_next = poll_reg.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            level_reg      <= LVL_DISARMED;
            entry_reg      <= '0;
            hold_reg       <= 1'b0;
        end
        else
        begin
            poll_valid_reg <= poll_valid_next;
            out_valid_reg  <= out_valid_next;
            level_reg      <= level_next;
            entry_reg      <= entry_next;
            hold_reg       <= hold_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            poll_reg.now_ms      <= now_ms;
            poll_reg.armed       <= armed;
            poll_reg.gate_open   <= gate_open;
            poll_reg.lockdown    <= lockdown;
            poll_reg.reset_press <= reset_press;
        end
        if (poll_go)
        begin
            acting_reg    <= level_reg;
            new_level_reg <= res.next_level;
            beep_reg      <= res.beep;
            changed_reg   <= res.changed;
        end
    end

    assign out_valid     = out_valid_reg;
    assign acting_level  = acting_reg;
    assign new_level     = new_level_reg;
    assign beep_code     = beep_reg;
    assign level_changed = changed_reg;

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level_changed == (new_level != acting_level)))
        else $error("level_changed disagrees with levels");

    a_level_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (new_level != 3'd6 && new_level != 3'd7))
        else $error("unreachable level code reported");

    a_long_beep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && beep_code == BEEP_LONG_TWICE) |->
            (new_level == LVL_SHOUT || new_level == LVL_SIREN))
        else $error("long beep without escalation to level 2 or 1");

    a_quiet_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !level_changed && beep_code != BEEP_NONE) |->
            (new_level == LVL_GUARD && beep_code == BEEP_SHORT))
        else $error("beep without level change outside a reset press");

    a_state_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        poll_go |=> (level_reg == new_level && out_valid))
        else $error("level state and result register disagree");

endmodule

FILE: tb/alarm_escalation_controller_core_tb.sv
// self-checking testbench for the alarm escalation controller core
module alarm_escalation_controller_core_tb;
    import aec_pkg::*;

    // index with no register behind it, writes there must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [TIME_W-1:0] now;
        logic              arm;
        logic              gate;
        logic              lock;
        logic              press;
        bit                drain;
    } poll_stim_t;

    typedef struct {
        logic [2:0] acting;
        logic [2:0] next;
        logic [2:0] beep;
        logic       changed;
    } alarm_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [TIME_W-1:0] now_ms = '0;
    logic              armed = 1'b0;
    logic              gate_open = 1'b0;
    logic              lockdown = 1'b0;
    logic              reset_press = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        acting_level;
    logic [2:0]        new_level;
    logic [2:0]        beep_code;
    logic              level_changed;

    alarm_escalation_controller_core u_dut (.*);

    always #5 clk = ~clk;

    // shadow copy of the controller state and thresholds
    logic [2:0]         lvl_now = LVL_DISARMED;
    logic [TIME_W-1:0]  lvl_since = '0;
    logic               guard_hold = 1'b0;
    logic [DWELL_W-1:0] warn_thr = WARN_DWELL_RST;
    logic [DWELL_W-1:0] speak_thr = SPEAK_DWELL_RST;
    logic [DWELL_W-1:0] shout_thr = SHOUT_DWELL_RST;

    poll_stim_t    poll_q[$];
    alarm_result_t escalation_q[$];
    poll_stim_t    cur_poll;
    logic [TIME_W-1:0] wall_ms = '0;
    bit            pause_next = 1'b0;
    bit            calm = 1'b0;
    int unsigned   mismatch_count = 0;
    int unsigned   polls_sent = 0;
    int unsigned   results_seen = 0;
    int unsigned   settings_run = 1;

    function automatic alarm_result_t escalate_poll(poll_stim_t p);
        alarm_result_t r;
        logic [2:0]        from;
        logic [2:0]        to;
        logic [2:0]        tone;
        logic [TIME_W-1:0] dwell;
        from = lvl_now;
        to = from;
        tone = BEEP_NONE;
        dwell = p.now - lvl_since;
        if (p.press)
        begin
            guard_hold = 1'b1;
            to = LVL_GUARD;
            tone = BEEP_SHORT;
        end
        else if (from == LVL_DISARMED)
        begin
            if (p.arm)
            begin
                to = LVL_GUARD;
                tone = BEEP_DOUBLE;
            end
        end
        else if (from >= LVL_SIREN && from <= LVL_GUARD && !p.arm)
        begin
            to = LVL_DISARMED;
            tone = BEEP_SHORT;
        end
        else
        begin
            case (from)
                LVL_GUARD:
                    if (!p.gate)
                    begin
                        guard_hold = 1'b0;
                    end
                    else if (!guard_hold)
                    begin
                        to = p.lock ? LVL_SHOUT : LVL_WARN;
                        tone = p.lock ? BEEP_LONG_TWICE : BEEP_DOUBLE;
                    end
                LVL_WARN, LVL_SPEAK:
                    if (!p.gate)
                    begin
                        to = LVL_GUARD;
                        tone = BEEP_SHORT;
                    end
                    else if (dwell >= {12'd0, (from == LVL_WARN) ? warn_thr : speak_thr})
                    begin
                        to = from - 3'd1;
                        tone = BEEP_DOUBLE;
                    end
                LVL_SHOUT:
                    if (dwell >= {12'd0, shout_thr})
                    begin
                        to = LVL_SIREN;
                        tone = BEEP_LONG_TWICE;
                    end
                default: ;
            endcase
        end
        if (to != from)
            lvl_since = p.now;
        lvl_now = to;
        r.acting = from;
        r.next = to;
        r.beep = tone;
        r.changed = (to != from);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatch_count++;
        // keep the log short if everything goes wrong
        if (mismatch_count <= 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // poll driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                escalation_q.push_back(escalate_poll(cur_poll));
                polls_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (poll_q.size() != 0 && !(poll_q[0].drain && escalation_q.size() != 0)
                    && (calm || $urandom_range(0, 99) >= 18))
                begin
                    cur_poll = poll_q.pop_front();
                    in_valid <= 1'b1;
                    now_ms <= cur_poll.now;
                    armed <= cur_poll.arm;
                    gate_open <= cur_poll.gate;
                    lockdown <= cur_poll.lock;
                    reset_press <= cur_poll.press;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int unsigned rx_hold_left = 0;
    bit          rx_hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        alarm_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (escalation_q.size() == 0)
                begin
                    flag_mismatch("transaction with nothing pending, new_level", new_level, 0);
                end
                else
                begin
                    want = escalation_q.pop_front();
                    if (acting_level !== want.acting)
                        flag_mismatch("acting_level", acting_level, want.acting);
                    if (new_level !== want.next)
                        flag_mismatch("new_level", new_level, want.next);
                    if (beep_code !== want.beep)
                        flag_mismatch("beep_code", beep_code, want.beep);
                    if (level_changed !== want.changed)
                        flag_mismatch("level_changed", level_changed, want.changed);
                end
            end
            // one long stall mid run so the pipeline backs up into the poll side
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (!rx_hold_done && results_seen >= 560)
            begin
                rx_hold_done = 1'b1;
                rx_hold_left = 80;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || $urandom_range(0, 99) >= 18;
            end
        end
    end

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic add_poll(input logic [TIME_W-1:0] t, input bit a, input bit g,
                            input bit l, input bit r);
        poll_stim_t s;
        s.now = t;
        s.arm = a;
        s.gate = g;
        s.lock = l;
        s.press = r;
        s.drain = pause_next;
        pause_next = 1'b0;
        poll_q.push_back(s);
    endtask

    // mostly armed walks with an advancing clock, some jumps anywhere in time
    task automatic queue_walk(input int count, input int unsigned max_step);
        int unsigned pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                wall_ms = $urandom;
            else if (pick < 20)
                wall_ms += $urandom_range(0, max_step / 8);
            else
                wall_ms += $urandom_range(0, max_step);
            add_poll(wall_ms, chance(90), chance(65), chance(30), chance(4));
        end
    endtask

    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        while ((poll_q.size() != 0 || in_valid || escalation_q.size() != 0) && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_dwell(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WARN:  warn_thr = data[DWELL_W-1:0];
            REG_SPEAK: speak_thr = data[DWELL_W-1:0];
            REG_SHOUT: shout_thr = data[DWELL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic read_dwell(input logic [1:0] idx, input logic [DWELL_W-1:0] want);
        logic [DATA_W-1:0] got;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== {{(DATA_W - DWELL_W){1'b0}}, want})
            flag_mismatch("prdata", got, want);
    endtask

    task automatic set_dwells(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] s,
                              input logic [DATA_W-1:0] h);
        write_dwell(REG_WARN, w);
        write_dwell(REG_SPEAK, s);
        write_dwell(REG_SHOUT, h);
        read_dwell(REG_WARN, warn_thr);
        read_dwell(REG_SPEAK, speak_thr);
        read_dwell(REG_SHOUT, shout_thr);
        settings_run++;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds, then one pass through the transitions (all but warn or speak to disarmed)
        read_dwell(REG_WARN, warn_thr);
        read_dwell(REG_SPEAK, speak_thr);
        read_dwell(REG_SHOUT, shout_thr);
        add_poll(32'd0, 0, 0, 0, 0);
        add_poll(32'd5, 1, 0, 0, 0);
        add_poll(32'd10, 1, 1, 0, 0);
        add_poll(32'd8009, 1, 1, 0, 0);
        add_poll(32'd8010, 1, 1, 0, 0);
        add_poll(32'd16010, 1, 1, 0, 0);
        add_poll(32'd26009, 1, 0, 0, 0);
        add_poll(32'd26010, 1, 0, 0, 0);
        add_poll(32'd26020, 1, 1, 1, 0);
        add_poll(32'd26030, 0, 1, 0, 0);
        add_poll(32'd26040, 0, 0, 0, 1);    // press while disarmed
        add_poll(32'd26050, 1, 1, 0, 0);    // held off from escalating
        add_poll(32'd26060, 1, 0, 0, 0);    // gate closed releases the hold
        add_poll(32'd26070, 1, 1, 1, 0);    // lockdown straight to shout
        add_poll(32'd26080, 0, 1, 0, 0);
        add_poll(32'd26090, 1, 0, 0, 0);
        add_poll(32'd26100, 1, 1, 0, 0);
        add_poll(32'd26110, 1, 0, 0, 0);
        add_poll(32'd26120, 1, 1, 0, 0);
        add_poll(32'd34120, 1, 1, 0, 0);
        add_poll(32'd34130, 1, 0, 0, 0);
        add_poll(32'd34140, 0, 0, 0, 0);
        add_poll(32'd34150, 1, 1, 0, 0);
        // dwell measured across the timer wrap
        add_poll(32'hFFFF_FF00, 1, 1, 0, 0);
        add_poll(32'h0000_1E3F, 1, 1, 0, 0);
        add_poll(32'h0000_1E40, 1, 1, 0, 0);
        add_poll(32'hFFFF_FFFF, 1, 1, 1, 1);
        wait_idle();

        // zero dwell advances on the first poll at a level
        set_dwells(32'd0, 32'd0, 32'd0);
        wall_ms = 32'd40000;
        queue_walk(200, 50);
        wait_idle();

        // upper bits dropped, largest thresholds, clock crossing the wrap
        set_dwells(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wall_ms = 32'hFFF0_0000;
        queue_walk(250, 600000);
        wait_idle();

        // unused index must leave everything alone; no idling here
        write_dwell(REG_UNUSED, 32'h0000_0005);
        set_dwells($urandom_range(1, 3000), $urandom_range(1, 3000),
                   $urandom_range(1, 3000));
        calm = 1'b1;
        queue_walk(200, 1500);
        pause_next = 1'b1;
        queue_walk(150, 1500);
        wait_idle();
        calm = 1'b0;

        set_dwells($urandom_range(1, 500), $urandom_range(1, 500), $urandom_range(1, 500));
        queue_walk(350, 300);
        wait_idle();

        $display("ran %0d polls and checked %0d results over %0d threshold settings",
                 polls_sent, results_seen, settings_run);
        $display("%0d mismatches, %0d results still owed", mismatch_count,
                 escalation_q.size());
        if (mismatch_count == 0 && escalation_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("timeout waiting for traffic to finish");
        $display("Some tests failed");
        $finish;
    end

endmodule
